[sv/vrc_pkg.sv]
// Shared constants for the rainbow colour map core and its checker.
`default_nettype none

package vrc_pkg;

  // Width of the cell value and full scale words at the ports
  localparam int unsigned PORT_BITS      = 32;
  // Default number of value bits actually used
  localparam int unsigned VALUE_BITS_DEF = 32;
  // Channel intensity width
  localparam int unsigned CHAN_BITS      = 8;

  // Top of the ramp, one channel at full intensity
  localparam logic [CHAN_BITS-1:0] RAMP_TOP = CHAN_BITS'(250);

  // Scaled hue Q = floor(HUE_SCALE * e / (3 * d)), with 3125/3 = 250*250/60
  localparam int unsigned HUE_SCALE      = 3125;
  localparam int unsigned HUE_SCALE_BITS = 12;
  // Q stays below 2048, so the divider yields this many quotient bits
  localparam int unsigned QUO_BITS       = 11;

  // Segment boundaries on the scaled hue
  localparam logic [QUO_BITS-1:0] SEG_1 = QUO_BITS'(250);
  localparam logic [QUO_BITS-1:0] SEG_2 = QUO_BITS'(500);
  localparam logic [QUO_BITS-1:0] SEG_3 = QUO_BITS'(750);
  localparam logic [QUO_BITS-1:0] SEG_4 = QUO_BITS'(1000);

endpackage : vrc_pkg

`default_nettype wire

[sv/value_to_rainbow_color_core.sv]
// Rainbow false-colour map: one cell value in, one RGB pixel out, fully pipelined.
//
// Channels: the input channel (in_valid_i / in_ready_o) carries a cell value
// and a frame-end flag; the output channel (out_valid_o / out_ready_i) carries
// red, green, blue and the frame-end flag. The configuration channel
// (cfg_valid_i / cfg_ready_o) writes the full scale word; it is always ready
// and must only be used while no word is in flight.
// Throughput: one word per cycle when nothing stalls. The pipeline is an
// input stage (saturate and subtract), a constant multiply stage, an
// 11-stage restoring divider giving one quotient bit per stage, and an output
// register that maps the scaled hue to the three channels.
// Reset: all valid bits clear, the pipeline is empty and full scale is 1.
// Stalls: each stage advances when it is empty or its successor advances, so
// a stalled receiver fills the bubbles first; the input stays ready until
// every stage holds a word. Nothing is dropped or repeated.
`default_nettype none

module value_to_rainbow_color_core
  import vrc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [PORT_BITS-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [PORT_BITS-1:0] cell_value_i,
  input  wire logic                 last_cell_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [CHAN_BITS-1:0] red_o,
  output      logic [CHAN_BITS-1:0] green_o,
  output      logic [CHAN_BITS-1:0] blue_o,
  output      logic                 last_pixel_o
);

  localparam int unsigned DEN_W = VALUE_BITS + 2;
  localparam int unsigned NUM_W = VALUE_BITS + HUE_SCALE_BITS;
  // input stage, multiply stage, divider stages, output stage
  localparam int unsigned NST   = QUO_BITS + 3;
  localparam int unsigned DIV0  = 2;

  // ---------------------------------------------------------------------------
  // Full scale register and its triple (the divisor)
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] fs_q, fs_d;
  logic [DEN_W-1:0]      den3_q, den3_d;
  logic [VALUE_BITS-1:0] cfg_masked;

  assign cfg_ready_o = 1'b1;
  assign cfg_masked  = cfg_data_i[VALUE_BITS-1:0];

  always_comb begin
    fs_d   = (cfg_masked == '0) ? VALUE_BITS'(1) : cfg_masked;
    den3_d = DEN_W'(fs_d) + (DEN_W'(fs_d) << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= VALUE_BITS'(1);
      den3_q <= DEN_W'(3);
    end else if (cfg_valid_i) begin
      fs_q   <= fs_d;
      den3_q <= den3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic [NST-1:0] valid_q;
  logic [NST-1:0] last_q;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      last_q[0] <= last_cell_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: saturate and take the distance from full scale
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS-1:0] dist_q, dist_d;

  assign val_in = cell_value_i[VALUE_BITS-1:0];

  always_comb begin
    dist_d = (val_in > fs_q) ? '0 : (fs_q - val_in);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dist_q <= dist_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dividend = distance * 3125
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      num_q <= NUM_W'(dist_q) * NUM_W'(HUE_SCALE);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: one quotient bit each, most significant first
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0]    rem_q [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int unsigned BIT = QUO_BITS - 1 - j;

    logic [NUM_W-1:0]    rem_in;
    logic [QUO_BITS-1:0] quo_in;
    logic [NUM_W-1:0]    trial;
    logic                fits;

    if (j == 0) begin : g_first
      assign rem_in = num_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = NUM_W'(den3_q) << BIT;
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (adv[DIV0+j]) begin
        rem_q[j] <= fits ? (rem_in - trial) : rem_in;
        quo_q[j] <= quo_in | (QUO_BITS'(fits) << BIT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: map the scaled hue onto the three ramps
  // ---------------------------------------------------------------------------
  logic [QUO_BITS-1:0]  hue;
  logic [QUO_BITS-1:0]  hue_up;
  logic [CHAN_BITS-1:0] red_d, green_d, blue_d;
  logic [CHAN_BITS-1:0] red_q, green_q, blue_q;

  assign hue = quo_q[QUO_BITS-1];
  // ceiling of the exact hue, for the falling ramps
  assign hue_up = hue + QUO_BITS'(rem_q[QUO_BITS-1] != '0);

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    priority if (hue < SEG_1) begin
      red_d   = RAMP_TOP;
      green_d = hue[CHAN_BITS-1:0];
    end else if (hue < SEG_2) begin
      red_d   = CHAN_BITS'(SEG_2 - hue_up);
      green_d = RAMP_TOP;
    end else if (hue < SEG_3) begin
      green_d = RAMP_TOP;
      blue_d  = CHAN_BITS'(hue - SEG_2);
    end else if (hue < SEG_4) begin
      green_d = CHAN_BITS'(SEG_4 - hue_up);
      blue_d  = RAMP_TOP;
    end else begin
      red_d   = CHAN_BITS'(hue - SEG_4);
      blue_d  = RAMP_TOP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NST-1]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o  = valid_q[NST-1];
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign last_pixel_o = last_q[NST-1];

endmodule : value_to_rainbow_color_core

`default_nettype wire

[sv/vrc_checker.sv]
// Port-level checker for the rainbow colour map core, with its bind.
`default_nettype none

module vrc_checker
  import vrc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [CHAN_BITS-1:0] red_o,
  input wire logic [CHAN_BITS-1:0] green_o,
  input wire logic [CHAN_BITS-1:0] blue_o,
  input wire logic                 last_pixel_o
);

  // every channel stays on the ramp
  a_chan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o <= RAMP_TOP && green_o <= RAMP_TOP && blue_o <= RAMP_TOP))
    else $error("channel above ramp top");

  // each hue segment has one channel at full intensity
  a_one_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o == RAMP_TOP || green_o == RAMP_TOP || blue_o == RAMP_TOP))
    else $error("no channel at full intensity");

  // and one channel dark
  a_one_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o == '0 || green_o == '0 || blue_o == '0))
    else $error("no channel dark");

  // hold a stalled word
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o)
       && $stable(last_pixel_o)))
    else $error("stalled output word changed");

endmodule : vrc_checker

bind value_to_rainbow_color_core vrc_checker u_vrc_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the rainbow colour map core.
`timescale 1ns / 100ps

module testbench;
  import vrc_pkg::*;

  localparam int unsigned CALM_ITEMS = 150;
  localparam int unsigned SHOWN_MAX  = 10;
  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS_DEF) - 64'd1;

  typedef enum logic [1:0] {ACT_CELL, ACT_WRITE, ACT_HOLD} act_e;

  typedef struct packed {
    act_e                 act;
    logic [PORT_BITS-1:0] data;
    logic                 last;
  } step_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 last;
  } pixel_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [PORT_BITS-1:0] cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [PORT_BITS-1:0] cell_value_i = '0;
  logic                 last_cell_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [CHAN_BITS-1:0] red_o;
  logic [CHAN_BITS-1:0] green_o;
  logic [CHAN_BITS-1:0] blue_o;
  logic                 last_pixel_o;

  step_t                stream_q[$];
  pixel_t               due_pixels[$];
  logic [PORT_BITS-1:0] full_scale = 32'd1;
  logic                 in_taken   = 1'b0;
  logic                 cfg_taken  = 1'b0;
  int unsigned          gap_left   = 0;
  int unsigned          stall_left = 0;
  int unsigned          errors     = 0;

  value_to_rainbow_color_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_value_i (cell_value_i),
    .last_cell_i  (last_cell_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_pixel_o (last_pixel_o)
  );

  always #1 clk_i = ~clk_i;

  // floor(250 * num / (60 * den))
  function automatic logic [63:0] hue_ramp(logic [63:0] num, logic [63:0] den);
    return (64'd250 * num) / (64'd60 * den);
  endfunction

  function automatic pixel_t rainbow_pixel(logic [PORT_BITS-1:0] scale,
                                           logic [PORT_BITS-1:0] value, logic last);
    logic [63:0] d, v, n, r, g, b;
    pixel_t      p;
    d = 64'(scale) & VALUE_MASK;
    v = 64'(value) & VALUE_MASK;
    if (d == 64'd0) d = 64'd1;
    if (v > d) v = d;
    n = 64'd250 * (d - v);
    if (n < 64'd60 * d) begin
      r = 64'd250;
      g = hue_ramp(n, d);
      b = 64'd0;
    end else if (n < 64'd120 * d) begin
      r = hue_ramp(64'd120 * d - n, d);
      g = 64'd250;
      b = 64'd0;
    end else if (n < 64'd180 * d) begin
      r = 64'd0;
      g = 64'd250;
      b = hue_ramp(n - 64'd120 * d, d);
    end else if (n < 64'd240 * d) begin
      r = 64'd0;
      g = hue_ramp(64'd240 * d - n, d);
      b = 64'd250;
    end else begin
      r = hue_ramp(n - 64'd240 * d, d);
      g = 64'd0;
      b = 64'd250;
    end
    p.red   = r[CHAN_BITS-1:0];
    p.green = g[CHAN_BITS-1:0];
    p.blue  = b[CHAN_BITS-1:0];
    p.last  = last;
    return p;
  endfunction

  task automatic add_cell(logic [PORT_BITS-1:0] value, logic last);
    stream_q.push_back('{ACT_CELL, value, last});
  endtask

  task automatic add_write(logic [PORT_BITS-1:0] scale);
    stream_q.push_back('{ACT_WRITE, scale, 1'b0});
  endtask

  task automatic add_hold();
    stream_q.push_back('{ACT_HOLD, '0, 1'b0});
  endtask

  // Mostly in-range values, with saturation, segment edges and raw noise mixed in
  task automatic random_phase(logic [PORT_BITS-1:0] scale, int unsigned count);
    logic [63:0]          d, edge_v;
    logic [PORT_BITS-1:0] v;
    int unsigned          pick;
    add_write(scale);
    d = (scale == '0) ? 64'd1 : 64'(scale);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        6: v = (scale == '1) ? $urandom : $urandom_range(32'hFFFF_FFFF, d[31:0] + 32'd1);
        7: v = $urandom;
        8: begin
          edge_v = (d * 64'($urandom_range(1, 4)) * 64'd60 + 64'd249) / 64'd250;
          edge_v = d - edge_v + 64'($urandom_range(0, 2));
          if (edge_v > 64'd0) edge_v = edge_v - 64'd1;
          if (edge_v > d) edge_v = d;
          v = edge_v[31:0];
        end
        9: begin
          case ($urandom_range(0, 2))
            0: v = '0;
            1: v = d[31:0];
            default: v = (d > 64'd1) ? d[31:0] - 32'd1 : d[31:0];
          endcase
        end
        default: v = $urandom_range(d[31:0], 0);
      endcase
      add_cell(v, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 199) == 0) add_hold();
    end
  endtask

  // Driver: present one word at a time, drain before any register write
  always @(negedge clk_i) begin : drive
    logic nv, ncv;
    nv  = in_valid_i;
    ncv = cfg_valid_i;
    if (rst_ni) begin
      if (in_taken) nv = 1'b0;
      if (cfg_taken) ncv = 1'b0;
      if (!nv && !ncv) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (stream_q.size() != 0) begin
          case (stream_q[0].act)
            ACT_CELL: begin
              nv = 1'b1;
              cell_value_i <= stream_q[0].data;
              last_cell_i  <= stream_q[0].last;
              void'(stream_q.pop_front());
              if (stream_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 8);
            end
            ACT_WRITE: begin
              if (due_pixels.size() == 0) begin
                ncv = 1'b1;
                cfg_data_i <= stream_q[0].data;
                void'(stream_q.pop_front());
              end
            end
            default: begin
              if (due_pixels.size() == 0) void'(stream_q.pop_front());
            end
          endcase
        end
      end
    end
    in_valid_i  <= nv;
    cfg_valid_i <= ncv;
  end

  // Receiver back-pressure in bursts, none near the end
  always @(negedge clk_i) begin : sink
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (stream_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 8);
    end
  end

  // Monitor: predict on acceptance, check each output word against the oldest prediction
  always @(posedge clk_i) begin : watch
    pixel_t want, got;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && in_ready_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) full_scale = cfg_data_i;
      if (in_valid_i && in_ready_o)
        due_pixels.push_back(rainbow_pixel(full_scale, cell_value_i, last_cell_i));
      if (out_valid_o && out_ready_i) begin
        got = '{red_o, green_o, blue_o, last_pixel_o};
        if (due_pixels.size() == 0) begin
          errors++;
          if (errors <= SHOWN_MAX)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                     $realtime, got.red, got.green, got.blue, got.last);
        end else begin
          want = due_pixels.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= SHOWN_MAX)
              $display("%0t: pixel expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                       $realtime, want.red, want.green, want.blue, want.last,
                       got.red, got.green, got.blue, got.last);
          end
        end
      end
    end
  end

  initial begin
    // Reset value of full scale first, then an evenly divisible scale for the segment edges
    add_cell(32'd0, 1'b0);
    add_cell(32'd1, 1'b1);
    add_cell(32'd2, 1'b0);
    add_cell(32'hFFFF_FFFF, 1'b1);
    add_write(32'd300);
    add_cell(32'd0, 1'b0);
    add_cell(32'd12, 1'b1);
    add_cell(32'd84, 1'b0);
    add_cell(32'd156, 1'b1);
    add_cell(32'd228, 1'b0);
    add_cell(32'd227, 1'b0);
    add_cell(32'd229, 1'b1);
    add_cell(32'd150, 1'b0);
    add_cell(32'd300, 1'b1);
    add_cell(32'd301, 1'b0);
    add_cell(32'hAAAA_AAAA, 1'b1);
    add_cell(32'h5555_5555, 1'b0);
    // Zero scale behaves as one
    add_write(32'd0);
    add_cell(32'd0, 1'b1);
    add_cell(32'd5, 1'b0);
    add_cell(32'hFFFF_FFFF, 1'b1);

    random_phase(32'd1, 80);
    random_phase(32'd2, 80);
    random_phase(32'd7, 100);
    random_phase(32'd250, 120);
    add_hold();
    random_phase(32'd1000, 150);
    random_phase($urandom_range(5000, 3), 150);
    random_phase($urandom, 150);
    random_phase(32'hFFFF_FFFF, 200);
    random_phase(32'h8000_0000, 100);
    random_phase(32'd600, 150);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stream_q.size() != 0 || in_valid_i || cfg_valid_i) @(posedge clk_i);
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
